>>> hdl/haar_wavelet_image_fusion_core_defines.svh
// Assertion macros shared by the checker files of the Haar fusion core.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef HAAR_WAVELET_IMAGE_FUSION_CORE_DEFINES_SVH
`define HAAR_WAVELET_IMAGE_FUSION_CORE_DEFINES_SVH

// checked only out of reset
`define HWF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HWF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/hwf_pkg.sv
// Shared constants and types of the Haar wavelet image fusion core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package hwf_pkg;

	localparam int MAX_IMAGES = 16;
	localparam int PIX_W      = 8;
	localparam int LANES      = 4;
	// image count, 0..MAX_IMAGES
	localparam int CNT_W      = $clog2(MAX_IMAGES + 1);
	// sum of approximation coefficients over a full group
	localparam int SUM_W      = $clog2(4 * 255 * MAX_IMAGES + 1);
	// signed detail coefficient, -510..510
	localparam int DET_W      = 11;
	// signed +-V+-H+-D, -1530..1530
	localparam int X_W        = 12;
	localparam int PROD_W     = X_W + CNT_W + 1;
	localparam int NUM_W      = PROD_W + 1;
	// magnitude bits of a non-negative numerator = quotient bits
	localparam int QW         = NUM_W - 1;
	localparam int DEN_W      = CNT_W + 2;
	localparam int ITER_W     = $clog2(QW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_LOAD,
		ST_DIV,
		ST_ROUND
	} state_t;

	typedef struct packed {
		logic accept;  // take the input item into the accumulators
		logic prod;    // form n * (+-V+-H+-D) per lane
		logic load;    // form numerators, start the divider
		logic step;    // one restoring-division step
		logic finish;  // round into the output register, clear the group
	} cmd_t;

endpackage

>>> hdl/hwf_ctrl.sv
// Controller of the Haar fusion core: sequences accumulate, multiply,
// bit-serial divide and round. Depends on hwf_pkg.
`timescale 1ns / 1ps

module hwf_ctrl
	import hwf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       last_image,
	output logic       m_tvalid,
	input  logic       m_tready,
	output cmd_t       cmd
);

	state_t              state_q, state_nx;
	logic [ITER_W-1:0]   iter_q;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				iter_q <= ITER_W'(QW - 1);
			end else if (cmd.step) begin
				iter_q <= iter_q - 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (last_image) begin
						state_nx = ST_PROD;
					end
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_nx = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (iter_q == '0) begin
					state_nx = ST_ROUND;
				end
			end
			ST_ROUND: begin
				// wait until the previous result has left the output register
				if (out_free) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/hwf_datapath.sv
// Datapath of the Haar fusion core: coefficient accumulators, four
// multiply/divide/round lanes and the output register. Depends on hwf_pkg.
`timescale 1ns / 1ps

module hwf_datapath
	import hwf_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic [4*PIX_W-1:0]      in_pix,
	output logic [4*PIX_W-1:0]      out_pix,
	output logic                    out_ovf
);

	// group accumulators
	logic        [SUM_W-1:0]  sum_q;
	logic        [CNT_W-1:0]  cnt_q;
	logic                     ovf_q;
	logic signed [DET_W-1:0]  vmax_q, hmax_q, dmax_q;

	// lanes
	logic signed [PROD_W-1:0] prod_q [LANES];
	logic                     neg_q  [LANES];
	logic        [QW-1:0]     quo_q  [LANES];
	logic        [DEN_W-1:0]  rem_q  [LANES];

	logic [4*PIX_W-1:0]       out_pix_q;
	logic                     out_ovf_q;

	logic signed [DET_W-1:0]  pa, pb, pc, pd;
	logic signed [DET_W-1:0]  v_in, h_in, d_in;
	logic        [SUM_W-1:0]  s_in;
	logic        [DEN_W-1:0]  den;
	logic signed [X_W-1:0]    x_lane    [LANES];
	logic signed [NUM_W-1:0]  num_lane  [LANES];
	logic        [DEN_W:0]    shift_lane[LANES];
	logic        [DEN_W:0]    diff_lane [LANES];
	logic                     ge_lane   [LANES];
	logic        [PIX_W-1:0]  pix_lane  [LANES];

	assign pa = $signed({{(DET_W-PIX_W){1'b0}}, in_pix[0*PIX_W +: PIX_W]});
	assign pb = $signed({{(DET_W-PIX_W){1'b0}}, in_pix[1*PIX_W +: PIX_W]});
	assign pc = $signed({{(DET_W-PIX_W){1'b0}}, in_pix[2*PIX_W +: PIX_W]});
	assign pd = $signed({{(DET_W-PIX_W){1'b0}}, in_pix[3*PIX_W +: PIX_W]});

	assign v_in = pa + pb - pc - pd;
	assign h_in = pa - pb + pc - pd;
	assign d_in = pa - pb - pc + pd;
	assign s_in = SUM_W'(in_pix[0*PIX_W +: PIX_W]) + SUM_W'(in_pix[1*PIX_W +: PIX_W])
		+ SUM_W'(in_pix[2*PIX_W +: PIX_W]) + SUM_W'(in_pix[3*PIX_W +: PIX_W]);

	assign den = {cnt_q, 2'b00};

	// lane order: top left, top right, bottom left, bottom right
	assign x_lane[0] = X_W'(vmax_q) + X_W'(hmax_q) + X_W'(dmax_q);
	assign x_lane[1] = X_W'(vmax_q) - X_W'(hmax_q) - X_W'(dmax_q);
	assign x_lane[2] = X_W'(hmax_q) - X_W'(vmax_q) - X_W'(dmax_q);
	assign x_lane[3] = X_W'(dmax_q) - X_W'(vmax_q) - X_W'(hmax_q);

	always_comb begin
		logic [DEN_W:0] twice;
		logic           inc;
		logic [QW:0]    qr;
		for (int k = 0; k < LANES; k++) begin
			num_lane[k]   = NUM_W'($signed({1'b0, sum_q})) + NUM_W'(prod_q[k]);
			shift_lane[k] = {rem_q[k], quo_q[k][QW-1]};
			diff_lane[k]  = shift_lane[k] - {1'b0, den};
			ge_lane[k]    = shift_lane[k] >= {1'b0, den};
			// round half to even on the final quotient and remainder
			twice = {rem_q[k], 1'b0};
			inc   = (twice > {1'b0, den}) || ((twice == {1'b0, den}) && quo_q[k][0]);
			qr    = {1'b0, quo_q[k]} + (QW+1)'(inc);
			// a negative numerator always rounds to zero or below
			if (neg_q[k]) begin
				pix_lane[k] = '0;
			end else if (qr > (QW+1)'(255)) begin
				pix_lane[k] = '1;
			end else begin
				pix_lane[k] = qr[PIX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.finish) begin
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.accept) begin
			if (cnt_q >= CNT_W'(MAX_IMAGES)) begin
				ovf_q <= 1'b1;
			end else begin
				sum_q <= sum_q + s_in;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (cnt_q < CNT_W'(MAX_IMAGES))) begin
			if (cnt_q == '0) begin
				vmax_q <= v_in;
				hmax_q <= h_in;
				dmax_q <= d_in;
			end else begin
				if (v_in > vmax_q) vmax_q <= v_in;
				if (h_in > hmax_q) hmax_q <= h_in;
				if (d_in > dmax_q) dmax_q <= d_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES; k++) begin
			if (cmd.prod) begin
				prod_q[k] <= PROD_W'(x_lane[k]) * PROD_W'($signed({1'b0, cnt_q}));
			end
			if (cmd.load) begin
				neg_q[k] <= num_lane[k][NUM_W-1];
				quo_q[k] <= num_lane[k][QW-1:0];
				rem_q[k] <= '0;
			end else if (cmd.step) begin
				quo_q[k] <= {quo_q[k][QW-2:0], ge_lane[k]};
				rem_q[k] <= ge_lane[k] ? diff_lane[k][DEN_W-1:0] : shift_lane[k][DEN_W-1:0];
			end
		end
		if (cmd.finish) begin
			for (int k = 0; k < LANES; k++) begin
				out_pix_q[k*PIX_W +: PIX_W] <= pix_lane[k];
			end
			out_ovf_q <= ovf_q;
		end
	end

	assign out_pix = out_pix_q;
	assign out_ovf = out_ovf_q;

endmodule

>>> hdl/haar_wavelet_image_fusion_core.sv
// Haar wavelet image fusion core. Each input item is one 2x2 block of one
// source image; blocks of the same position from several images (up to
// MAX_IMAGES = 16, extras dropped and flagged) form a group closed by tuser.
// The core sums the approximation coefficient, keeps the maximum of each
// detail coefficient and, on the last image, outputs one fused 2x2 block
// rounded half to even and clipped to 0..255. A block that does not close
// a group is taken and ready stays high. A block that closes a group holds
// ready low after it through multiply, load, 18 divide steps (one per bit
// of the NUM_W - 1 = 18 bit quotient) and round, and longer while the
// previous item still waits for m_tready: four bit-serial dividers, one
// per output pixel, take one quotient bit per cycle. A finished item waits
// in the output register while the next group accumulates.
// Depends on hwf_pkg, hwf_ctrl and hwf_datapath.
`timescale 1ns / 1ps

module haar_wavelet_image_fusion_core
	import hwf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// pix_top_left, pix_top_right, pix_bottom_left, pix_bottom_right
	input  logic [4*PIX_W-1:0]   s_tdata,
	// last_image
	input  logic [0:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// fused_top_left, fused_top_right, fused_bottom_left, fused_bottom_right
	output logic [4*PIX_W-1:0]   m_tdata,
	// count_overflow
	output logic [0:0]           m_tuser
);

	cmd_t cmd;

	hwf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.last_image (s_tuser[0]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.cmd        (cmd)
	);

	hwf_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_pix  (s_tdata),
		.out_pix (m_tdata),
		.out_ovf (m_tuser[0])
	);

endmodule

>>> hdl/hwf_checker.sv
// Port-level checks of the Haar fusion core, bound to the top level.
// Depends on hwf_pkg and haar_wavelet_image_fusion_core_defines.svh.
`timescale 1ns / 1ps
`include "haar_wavelet_image_fusion_core_defines.svh"

module hwf_checker
	import hwf_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [0:0]         s_tuser,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [4*PIX_W-1:0] m_tdata,
	input logic [0:0]         m_tuser
);

	// a stalled result holds
	`HWF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	// closing a group starts the multiply, so no item is taken next cycle
	`HWF_ASSERT(a_last_busy, s_tvalid && s_tready && s_tuser[0] |=> !s_tready, "ready after a group-closing item")
	// an item that does not close a group keeps the input open
	`HWF_ASSERT(a_mid_ready, s_tvalid && s_tready && !s_tuser[0] |=> s_tready, "ready dropped inside a group")
	`HWF_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind haar_wavelet_image_fusion_core hwf_checker u_hwf_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for haar_wavelet_image_fusion_core: random groups of 2x2 blocks
// are streamed in, and each fused block is compared with a built-in integer predictor.
// Depends on hwf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top
	import hwf_pkg::*;
;

	localparam int N_ITEMS     = 1200;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYC    = 40;

	typedef struct {
		logic [7:0] tl, tr, bl, br;
		logic       last;
		logic       drain;  // hold this item back until every fused block is out
	} block_t;

	typedef struct {
		logic [7:0] tl, tr, bl, br;
		logic       ovf;
	} fused_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	block_t pend_q[$];
	fused_t fused_q[$];
	block_t nxt_blk;
	fused_t want;
	logic   s_taken = 1'b0;
	int     cyc = 0;
	int     stall_cyc = 0;
	int     n_err = 0;
	int     n_items = 0;
	logic   calm;

	// group accumulators of the predictor
	int   acc_sum, v_max, h_max, d_max, img_cnt;
	logic grp_ovf;

	haar_wavelet_image_fusion_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// no random idling on either side inside this window
	assign calm = (cyc >= 2000) && (cyc < 3500);

	// floor division, ties to even, then clip to a pixel
	function automatic logic [7:0] round_pix(input int num, input int den);
		int q, r;
		if (den <= 0)
			return 8'd0;
		q = num / den;
		r = num - q * den;
		if (r < 0) begin
			q -= 1;
			r += den;
		end
		if (2 * r > den)
			q += 1;
		else if (2 * r == den)
			q += q & 1;
		if (q < 0)
			return 8'd0;
		if (q > 255)
			return 8'd255;
		return q[7:0];
	endfunction

	task automatic fuse_block(input logic [31:0] px, input logic last);
		int a, b, c, d, s, v, h, g, den;
		fused_t f;
		a = int'(px[7:0]);
		b = int'(px[15:8]);
		c = int'(px[23:16]);
		d = int'(px[31:24]);
		s = a + b + c + d;
		v = a + b - c - d;
		h = a - b + c - d;
		g = a - b - c + d;
		if (img_cnt >= MAX_IMAGES) begin
			grp_ovf = 1'b1;
		end else begin
			if (img_cnt == 0 || v > v_max) v_max = v;
			if (img_cnt == 0 || h > h_max) h_max = h;
			if (img_cnt == 0 || g > d_max) d_max = g;
			acc_sum += s;
			img_cnt += 1;
		end
		if (last) begin
			den = 4 * img_cnt;
			f.tl = round_pix(acc_sum + img_cnt * ( v_max + h_max + d_max), den);
			f.tr = round_pix(acc_sum + img_cnt * ( v_max - h_max - d_max), den);
			f.bl = round_pix(acc_sum + img_cnt * (-v_max + h_max - d_max), den);
			f.br = round_pix(acc_sum + img_cnt * (-v_max - h_max + d_max), den);
			f.ovf = grp_ovf;
			fused_q = {fused_q, f};
			acc_sum = 0;
			v_max = 0;
			h_max = 0;
			d_max = 0;
			img_cnt = 0;
			grp_ovf = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			n_err++;
		end
	endtask

	task automatic add_block(input logic [7:0] a, b, c, d, input logic last,
			input logic drain = 1'b0);
		block_t blk;
		blk.tl = a;
		blk.tr = b;
		blk.bl = c;
		blk.br = d;
		blk.last = last;
		blk.drain = drain;
		pend_q = {pend_q, blk};
		n_items++;
	endtask

	function automatic logic [7:0] near_pix(input int base);
		int p;
		p = base + int'($urandom_range(0, 16)) - 8;
		if (p < 0) p = 0;
		if (p > 255) p = 255;
		return p[7:0];
	endfunction

	// images of one group: either unrelated or small variations of one block
	task automatic add_group(input int n_img, input logic drain);
		int ba, bb, bc, bd;
		logic similar;
		similar = 1'($urandom_range(0, 1));
		ba = $urandom_range(0, 255);
		bb = $urandom_range(0, 255);
		bc = $urandom_range(0, 255);
		bd = $urandom_range(0, 255);
		for (int i = 0; i < n_img; i++) begin
			if (similar)
				add_block(near_pix(ba), near_pix(bb), near_pix(bc), near_pix(bd),
					i == n_img - 1, drain && i == 0);
			else
				add_block(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					i == n_img - 1, drain && i == 0);
		end
	endtask

	// driver: new values at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_taken) begin
				if (pend_q.size() != 0 && !(pend_q[0].drain && fused_q.size() != 0)
						&& (calm || $urandom_range(0, 99) >= 15)) begin
					nxt_blk = pend_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {nxt_blk.br, nxt_blk.bl, nxt_blk.tr, nxt_blk.tl};
					s_tuser  <= nxt_blk.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 15);
		end
	end

	// monitor: results checked before the input item of the same edge is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			cyc <= cyc + 1;
			s_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				if (fused_q.size() == 0) begin
					$error("fused block with no group closed: %h / %b", m_tdata, m_tuser);
					n_err++;
				end else begin
					want = fused_q.pop_front();
					check_field("fused_top_left", int'(want.tl), int'(m_tdata[7:0]));
					check_field("fused_top_right", int'(want.tr), int'(m_tdata[15:8]));
					check_field("fused_bottom_left", int'(want.bl), int'(m_tdata[23:16]));
					check_field("fused_bottom_right", int'(want.br), int'(m_tdata[31:24]));
					check_field("count_overflow", int'(want.ovf), int'(m_tuser[0]));
				end
			end
			if (s_tvalid && s_tready)
				fuse_block(s_tdata, s_tuser[0]);
		end
	end

	// watchdog on cycles where neither side moves an item
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cyc <= 0;
		else
			stall_cyc <= stall_cyc + 1;
		if (stall_cyc >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		// a real falling edge on the reset, ahead of the first clock edge
		#1 arst_n = 1'b0;

		acc_sum = 0;
		v_max = 0;
		h_max = 0;
		d_max = 0;
		img_cnt = 0;
		grp_ovf = 1'b0;

		// single-image groups: black, white, one bright corner each way
		add_block(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		add_block(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		add_block(8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
		add_block(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
		// negative vertical detail: first image must overwrite the zero maximum
		add_block(8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
		add_block(8'd0, 8'd0, 8'd200, 8'd200, 1'b1);
		// maxima all from the first image, fractional means
		add_block(8'd1, 8'd0, 8'd0, 8'd0, 1'b0);
		add_block(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		// full group, then an extra image that carries the group close
		for (int i = 0; i < 17; i++)
			add_block(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), i == 16);

		// random groups; a few overflow, a few wait for the output to drain
		add_group($urandom_range(1, 16), 1'b1);
		while (n_items < N_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				add_group($urandom_range(17, 20), $urandom_range(0, 49) == 0);
			else if ($urandom_range(0, 5) == 0)
				add_group(16, $urandom_range(0, 49) == 0);
			else
				add_group($urandom_range(1, 8), $urandom_range(0, 49) == 0);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (fused_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (n_err == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
